@@ hw/rtl/mexp_pkg.sv @@
// Shared types for the modular exponentiation block.
package mexp_pkg;

    // Status of the shared modular multiplier as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

    // Smallest modulus the block keeps; smaller writes are raised to this
    localparam int unsigned MIN_MODULUS = 2;

endpackage

@@ hw/rtl/mexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier: a * b mod m, one bit of a per cycle.
module mexp_mulmod #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    input  logic [WORD_WIDTH-1:0] i_m,
    output logic [WORD_WIDTH-1:0] o_result,
    output mexp_pkg::t_mm_status  o_status
);

    localparam int CW = $clog2(WORD_WIDTH + 1);
    localparam int TW = WORD_WIDTH + 2;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [WORD_WIDTH-1:0] r_a, n_a;
    logic [WORD_WIDTH-1:0] r_b, n_b;
    logic [WORD_WIDTH-1:0] r_m, n_m;
    logic [WORD_WIDTH-1:0] r_acc, n_acc;

    logic [TW-1:0] t_sum;
    logic [TW-1:0] t_m1;
    logic [TW-1:0] t_m2;
    logic [TW-1:0] t_red;

    // Running value stays below m, so 2*acc + b < 3m: at most 2m to take off
    always_comb begin
        t_m1  = {2'b00, r_m};
        t_m2  = {1'b0, r_m, 1'b0};
        t_sum = {1'b0, r_acc, 1'b0} + (r_a[WORD_WIDTH-1] ? {2'b00, r_b} : '0);
        if (t_sum >= t_m2) begin
            t_red = t_sum - t_m2;
        end else if (t_sum >= t_m1) begin
            t_red = t_sum - t_m1;
        end else begin
            t_red = t_sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_acc  = r_acc;
        if (r_busy) begin
            n_acc = t_red[WORD_WIDTH-1:0];
            n_a   = {r_a[WORD_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WORD_WIDTH);
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
        r_acc <= n_acc;
    end

    assign o_result      = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

@@ hw/rtl/modular_exponentiation.sv @@
// Modular exponentiation top level: right-to-left square-and-multiply sequencer.
//
//  channel   | ports                                   | flow
//  ----------+-----------------------------------------+-------------------------------
//  command   | start, busy, i_base, i_exponent         | taken when start & !busy
//  result    | o_result_valid, o_power_mod             | one-cycle strobe, no back-off
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_modulus | written when valid & ready
//
// After the accepting edge the sequencer works through, W = WORD_WIDTH: one base
// reduction, W squarings and one product per set exponent bit, each in the one bit-serial
// multiplier, plus one pass through the decision state per exponent bit and one at the end,
// which raises the result strobe. Busy is high until the strobe cycle, at whose closing
// edge a new transaction may be taken.
// Reset sets the modulus to 2 and leaves the block idle.
// The result strobe lasts one cycle; the receiver cannot stall it.
module modular_exponentiation #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [WORD_WIDTH-1:0] i_base,
    input  logic [WORD_WIDTH-1:0] i_exponent,
    output logic                  o_result_valid,
    output logic [WORD_WIDTH-1:0] o_power_mod,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WORD_WIDTH-1:0] i_cfg_modulus
);

    localparam int CW = $clog2(WORD_WIDTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_NEXT   = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_SQR    = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [WORD_WIDTH-1:0] r_modulus;
    logic [WORD_WIDTH-1:0] r_exp, n_exp;
    logic [WORD_WIDTH-1:0] r_sq, n_sq;
    logic [WORD_WIDTH-1:0] r_acc, n_acc;
    logic [CW-1:0]         r_bit, n_bit;
    logic                  r_valid, n_valid;

    logic                  mm_start;
    logic [WORD_WIDTH-1:0] mm_a;
    logic [WORD_WIDTH-1:0] mm_b;
    logic [WORD_WIDTH-1:0] mm_result;
    mexp_pkg::t_mm_status  mm_status;

    mexp_mulmod #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_modulus),
        .o_result(mm_result),
        .o_status(mm_status)
    );

    always_comb begin
        n_state  = r_state;
        n_exp    = r_exp;
        n_sq     = r_sq;
        n_acc    = r_acc;
        n_bit    = r_bit;
        n_valid  = 1'b0;
        mm_start = 1'b0;
        mm_a     = r_sq;
        mm_b     = r_sq;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // reduce the base: base * 1 mod m
                    mm_start = 1'b1;
                    mm_a     = i_base;
                    mm_b     = WORD_WIDTH'(1);
                    n_exp    = i_exponent;
                    n_acc    = WORD_WIDTH'(1);
                    n_bit    = '0;
                    n_state  = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mm_status.done) begin
                    n_sq    = mm_result;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_bit == CW'(WORD_WIDTH)) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_exp[0]) begin
                    mm_start = 1'b1;
                    mm_a     = r_acc;
                    n_state  = ST_MUL;
                end else begin
                    mm_start = 1'b1;
                    n_state  = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_status.done) begin
                    // take the product and square straight away
                    n_acc    = mm_result;
                    mm_start = 1'b1;
                    n_state  = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mm_status.done) begin
                    n_sq    = mm_result;
                    n_exp   = {1'b0, r_exp[WORD_WIDTH-1:1]};
                    n_bit   = r_bit + 1'b1;
                    n_state = ST_NEXT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_bit     <= '0;
            r_modulus <= WORD_WIDTH'(mexp_pkg::MIN_MODULUS);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_bit   <= n_bit;
            if (i_cfg_valid && o_cfg_ready) begin
                // raise a modulus of 0 or 1 to the minimum
                if (i_cfg_modulus < WORD_WIDTH'(mexp_pkg::MIN_MODULUS)) begin
                    r_modulus <= WORD_WIDTH'(mexp_pkg::MIN_MODULUS);
                end else begin
                    r_modulus <= i_cfg_modulus;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_sq  <= n_sq;
        r_acc <= n_acc;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_power_mod    = r_acc;

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_power_mod < r_modulus))
        else $error("result not reduced below the modulus");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while a transaction is in flight");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_mm_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |-> !mm_status.busy)
        else $error("multiplier launched while still working");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the modular exponentiation block.

class ModPowerTracker;
    bit [31:0]   modulus;
    bit [31:0]   pending_powers[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
        modulus = mexp_pkg::MIN_MODULUS;
    endfunction

    // Raise writes below the minimum, as the block does
    function void load_modulus(bit [31:0] value);
        modulus = (value < mexp_pkg::MIN_MODULUS) ? mexp_pkg::MIN_MODULUS : value;
    endfunction

    function bit [31:0] expected_power(bit [31:0] base, bit [31:0] exponent);
        bit [63:0] m;
        bit [63:0] sq;
        bit [63:0] acc;
        m   = {32'b0, modulus};
        sq  = {32'b0, base} % m;
        acc = 64'd1;
        for (int i = 0; i < 32; i++) begin
            if (exponent[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[31:0];
    endfunction

    function void note_command(bit [31:0] base, bit [31:0] exponent);
        pending_powers.push_back(expected_power(base, exponent));
    endfunction

    task report_mismatch(string what);
        $display("%0t MISMATCH %s", $time, what);
        mismatches++;
    endtask

    task check_result(logic [31:0] got);
        bit [31:0] want;
        if (pending_powers.size() == 0) begin
            report_mismatch($sformatf("power_mod %h with no command outstanding", got));
            return;
        end
        want = pending_powers.pop_front();
        checked++;
        if (got !== want)
            report_mismatch($sformatf("power_mod %h, want %h (modulus %h)",
                                      got, want, modulus));
    endtask
endclass

module tb;

    localparam int      W            = 32;
    localparam int      CLK_PERIOD   = 8;
    localparam longint  LIMIT_CYCLES = 4_000_000;
    // Upper bound on the longest transaction, all exponent bits set, accept edge to result edge
    localparam int      MAX_LATENCY  = (W + 1) * (2 * W + 2) + 1;
    localparam int      RANDOM_PHASES    = 7;
    localparam int      ITEMS_PER_PHASE  = 37;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [W-1:0] i_base = '0;
    logic [W-1:0] i_exponent = '0;
    logic         o_result_valid;
    logic [W-1:0] o_power_mod;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [W-1:0] i_cfg_modulus = '0;

    ModPowerTracker tracker = new();
    int unsigned    commands_sent;
    int unsigned    modulus_writes;

    modular_exponentiation #(.WORD_WIDTH(W)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .o_result_valid (o_result_valid),
        .o_power_mod    (o_power_mod),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_modulus  (i_cfg_modulus)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1)
            tracker.check_result(o_power_mod);
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("modular_exponentiation verification failed");
        $finish;
    end

    // Mostly short gaps; some land anywhere inside a busy period, a few run past it
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, 3);
        else if (r < 95)
            return $urandom_range(0, MAX_LATENCY);
        return $urandom_range(MAX_LATENCY, MAX_LATENCY + 200);
    endfunction

    task automatic send_command(bit [31:0] base, bit [31:0] exponent);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        start      <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_command(base, exponent);
        commands_sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_base     <= $urandom;
            i_exponent <= $urandom;
            repeat (gap - 1) @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every outstanding transaction has returned
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending_powers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_modulus(bit [31:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.load_modulus(value);
        modulus_writes++;
        @(negedge i_clk);
        i_cfg_valid   <= 1'b0;
        i_cfg_modulus <= $urandom;
    endtask

    function automatic bit [31:0] pick_base(bit [31:0] m);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return m - 32'd1;
            3: return m;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] pick_exponent();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 64);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        bit [31:0] phase_moduli[RANDOM_PHASES];

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset modulus of two
        send_command(32'd0, 32'd0);
        send_command(32'd1, 32'd0);
        send_command(32'd3, 32'd5);
        send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Writes of zero and one must leave the modulus at two
        write_modulus(32'd0);
        send_command(32'd5, 32'd3);
        write_modulus(32'd1);
        send_command(32'd0, 32'd7);
        send_command(32'd6, 32'd0);

        write_modulus(32'hFFFF_FFFF);
        send_command(32'd0, 32'd0);
        send_command(32'd0, 32'd1);
        send_command(32'hFFFF_FFFF, 32'd1);
        send_command(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_command(32'hFFFF_FFFE, 32'd2);
        send_command(32'd12345, 32'd0);
        send_command(32'd2, 32'd31);
        send_command(32'd2, 32'd32);
        send_command(32'h1234_5678, 32'h8000_0000);

        // Largest 32-bit prime: Fermat gives one
        write_modulus(32'hFFFF_FFFB);
        send_command(32'hFFFF_FFFF, 32'hFFFF_FFFA);
        send_command(32'd7, 32'hFFFF_FFFA);

        write_modulus(32'd3);
        send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        phase_moduli[0] = 32'd3;
        phase_moduli[1] = 32'hFFFF_FFFB;
        phase_moduli[2] = 32'h8000_0000;
        phase_moduli[3] = $urandom_range(2, 255);
        phase_moduli[4] = $urandom;
        phase_moduli[5] = 32'hFFFF_FFFF;
        phase_moduli[6] = 32'd1;

        foreach (phase_moduli[p]) begin
            write_modulus(phase_moduli[p]);
            repeat (ITEMS_PER_PHASE)
                send_command(pick_base(tracker.modulus), pick_exponent());
        end

        drain();
        repeat (MAX_LATENCY) @(posedge i_clk);

        $display("Sent %0d commands across %0d modulus writes; %0d results compared.",
                 commands_sent, modulus_writes, tracker.checked);
        $display("Moduli spanned two to all-ones, including raised writes of zero and one.");
        if (tracker.mismatches == 0) begin
            $display("modular_exponentiation verification clean");
        end else begin
            $display("modular_exponentiation verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
dv/tb.sv
